FILE: hw/rtl/iee_pkg.sv
// Shared constants, codes, types and small functions for the infix expression evaluator.
// Used by iee_alu, infix_expression_evaluator_top and tb_top; depends on nothing.
package iee_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SD_W        = $clog2(STACK_DEPTH);
	localparam int CNT_W       = SD_W + 1;
	localparam int FRAC_BITS   = 32;
	localparam int MAX_DIGITS  = 19;
	localparam int DC_W        = 5;
	localparam int VAL_W       = 64;

	// operator stack codes, also the ALU opcodes
	localparam logic [2:0] OP_LPAREN = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_SUB    = 3'd2;
	localparam logic [2:0] OP_MUL    = 3'd3;
	localparam logic [2:0] OP_DIV    = 3'd4;
	localparam logic [2:0] OP_REM    = 3'd5;
	localparam logic [2:0] OP_CVT    = 3'd6;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_DIVZ = 3'd1;
	localparam logic [2:0] ST_OVF  = 3'd2;
	localparam logic [2:0] ST_MALF = 3'd3;
	localparam logic [2:0] ST_LONG = 3'd4;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef struct packed {
		logic       start;
		logic [2:0] op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_rsp_t;

	function automatic logic [VAL_W-1:0] pow10(input logic [DC_W-1:0] f);
		logic [VAL_W-1:0] p;
		case (f)
			5'd0:  p = 64'd1;
			5'd1:  p = 64'd10;
			5'd2:  p = 64'd100;
			5'd3:  p = 64'd1000;
			5'd4:  p = 64'd10000;
			5'd5:  p = 64'd100000;
			5'd6:  p = 64'd1000000;
			5'd7:  p = 64'd10000000;
			5'd8:  p = 64'd100000000;
			5'd9:  p = 64'd1000000000;
			5'd10: p = 64'd10000000000;
			5'd11: p = 64'd100000000000;
			5'd12: p = 64'd1000000000000;
			5'd13: p = 64'd10000000000000;
			5'd14: p = 64'd100000000000000;
			5'd15: p = 64'd1000000000000000;
			5'd16: p = 64'd10000000000000000;
			5'd17: p = 64'd100000000000000000;
			5'd18: p = 64'd1000000000000000000;
			5'd19: p = 64'd10000000000000000000;
			default: p = 64'd1;
		endcase
		return p;
	endfunction

	function automatic logic [1:0] level_of(input logic [2:0] code);
		logic [1:0] lv;
		case (code)
			OP_ADD, OP_SUB: lv = 2'd1;
			OP_LPAREN:      lv = 2'd0;
			default:        lv = 2'd2;
		endcase
		return lv;
	endfunction

	function automatic logic [2:0] char_to_op(input logic [7:0] ch);
		logic [2:0] c;
		case (ch)
			CH_PLUS:  c = OP_ADD;
			CH_MINUS: c = OP_SUB;
			CH_STAR:  c = OP_MUL;
			CH_SLASH: c = OP_DIV;
			default:  c = OP_REM;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/iee_alu.sv
// Shared iterative arithmetic unit: saturating add/sub, partial-product multiply,
// restoring divide/remainder and decimal-to-fixed conversion. Uses iee_pkg.
module iee_alu import iee_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  alu_req_t         req,
	input  logic [VAL_W-1:0] a,
	input  logic [VAL_W-1:0] b,
	input  logic [DC_W-1:0]  frac_digits,
	output alu_rsp_t         rsp,
	output logic [VAL_W-1:0] res
);

	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_DIV  = 2'd1;
	localparam logic [1:0] A_MUL  = 2'd2;
	localparam logic [1:0] A_FIN  = 2'd3;
	localparam int NW   = 2 * VAL_W;
	localparam int HALF = VAL_W / 2;

	logic [1:0]         ph_q;
	logic [2:0]         op_q;
	logic               neg_q;
	logic [NW-1:0]      n_q;
	logic [VAL_W-1:0]   d_q;
	logic [VAL_W:0]     r_q;
	logic [VAL_W-1:0]   q_q;
	logic               ovf_q;
	logic [7:0]         cnt_q;
	logic [VAL_W-1:0]   a_q;
	logic [VAL_W-1:0]   b_q;
	logic [VAL_W-1:0]   pp_q;
	logic [NW-1:0]      acc_q;
	logic               done_q;
	logic               divz_q;
	logic [VAL_W-1:0]   res_q;

	logic [VAL_W-1:0]   ma;
	logic [VAL_W-1:0]   mb;
	logic [VAL_W:0]     r_sh;
	logic [HALF-1:0]    mul_x;
	logic [HALF-1:0]    mul_y;
	logic [NW-1:0]      pp_shift;
	logic [VAL_W-1:0]   sum;
	logic [VAL_W-1:0]   dif;
	logic [VAL_W-1:0]   fin;
	logic               divz_now;

	function automatic logic [VAL_W-1:0] from_mag(input logic neg, input logic [VAL_W-1:0] m,
			input logic ovf);
		logic [VAL_W-1:0] v;
		if (neg) begin
			v = (ovf || m > NEG_MIN) ? NEG_MIN : (~m + 1'b1);
		end else begin
			v = (ovf || m > POS_MAX) ? POS_MAX : m;
		end
		return v;
	endfunction

	assign ma   = a[VAL_W-1] ? (~a + 1'b1) : a;
	assign mb   = b[VAL_W-1] ? (~b + 1'b1) : b;
	assign r_sh = {r_q[VAL_W-1:0], n_q[NW-1]};
	assign divz_now = (ph_q == A_IDLE) && req.start && (req.op == OP_DIV || req.op == OP_REM)
		&& (b == '0);

	// partial product order: lo*lo, lo*hi, hi*lo, hi*hi
	always_comb begin
		mul_x = cnt_q[1] ? a_q[VAL_W-1:HALF] : a_q[HALF-1:0];
		mul_y = cnt_q[0] ? b_q[VAL_W-1:HALF] : b_q[HALF-1:0];
		case (cnt_q[2:0])
			3'd1:    pp_shift = {{VAL_W{1'b0}}, pp_q};
			3'd4:    pp_shift = {pp_q, {VAL_W{1'b0}}};
			default: pp_shift = {{HALF{1'b0}}, pp_q, {HALF{1'b0}}};
		endcase
	end

	always_comb begin
		sum = a_q + b_q;
		dif = a_q - b_q;
		case (op_q)
			OP_ADD: begin
				fin = sum;
				if (a_q[VAL_W-1] == b_q[VAL_W-1] && sum[VAL_W-1] != a_q[VAL_W-1])
					fin = a_q[VAL_W-1] ? NEG_MIN : POS_MAX;
			end
			OP_SUB: begin
				fin = dif;
				if (a_q[VAL_W-1] != b_q[VAL_W-1] && dif[VAL_W-1] != a_q[VAL_W-1])
					fin = a_q[VAL_W-1] ? NEG_MIN : POS_MAX;
			end
			OP_MUL: fin = from_mag(neg_q, acc_q[FRAC_BITS+VAL_W-1:FRAC_BITS],
				|acc_q[NW-1:FRAC_BITS+VAL_W]);
			OP_DIV: fin = from_mag(neg_q, q_q, ovf_q);
			OP_REM: fin = from_mag(neg_q, r_q[VAL_W-1:0], 1'b0);
			default: begin
				// rounding: ties go up
				if (ovf_q || q_q[VAL_W-1])
					fin = POS_MAX;
				else if ({r_q, 1'b0} >= {2'b00, d_q})
					fin = (q_q == POS_MAX) ? POS_MAX : q_q + 1'b1;
				else
					fin = q_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			divz_q <= 1'b0;
		end else begin
			done_q <= (ph_q == A_FIN) || divz_now;
			divz_q <= divz_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= A_IDLE;
		end else begin
			case (ph_q)
				A_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						a_q   <= (req.op == OP_MUL) ? ma : a;
						b_q   <= (req.op == OP_MUL) ? mb : b;
						r_q   <= '0;
						q_q   <= '0;
						ovf_q <= 1'b0;
						cnt_q <= '0;
						acc_q <= '0;
						d_q   <= (req.op == OP_DIV || req.op == OP_REM) ? mb
							: pow10(frac_digits);
						case (req.op)
							OP_ADD, OP_SUB: ph_q <= A_FIN;
							OP_MUL: begin
								neg_q <= a[VAL_W-1] ^ b[VAL_W-1];
								ph_q  <= A_MUL;
							end
							OP_DIV, OP_REM: begin
								neg_q <= (req.op == OP_DIV) ? (a[VAL_W-1] ^ b[VAL_W-1])
									: a[VAL_W-1];
								n_q   <= (req.op == OP_DIV) ? ({{VAL_W{1'b0}}, ma} << FRAC_BITS)
									: {{VAL_W{1'b0}}, ma};
								if (b != '0)
									ph_q <= A_DIV;
							end
							default: begin
								neg_q <= 1'b0;
								n_q   <= {{VAL_W{1'b0}}, a} << FRAC_BITS;
								ph_q  <= A_DIV;
							end
						endcase
					end
				end
				A_DIV: begin
					if (q_q[VAL_W-1])
						ovf_q <= 1'b1;
					if (r_sh >= {1'b0, d_q}) begin
						r_q <= r_sh - {1'b0, d_q};
						q_q <= {q_q[VAL_W-2:0], 1'b1};
					end else begin
						r_q <= r_sh;
						q_q <= {q_q[VAL_W-2:0], 1'b0};
					end
					n_q   <= n_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 8'(NW - 1))
						ph_q <= A_FIN;
				end
				A_MUL: begin
					if (cnt_q[2:0] != 3'd4)
						pp_q <= mul_x * mul_y;
					if (cnt_q[2:0] != 3'd0)
						acc_q <= acc_q + pp_shift;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[2:0] == 3'd4)
						ph_q <= A_FIN;
				end
				default: begin
					res_q  <= fin;
					ph_q   <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = divz_q;
	assign res          = res_q;

endmodule

FILE: hw/rtl/infix_expression_evaluator_top.sv
// Top level of the infix expression evaluator: character intake, the two stacks
// and the sequencer. Depends on iee_pkg and iee_alu.
//
// Takes one ASCII character per item and, on the item flagged by tlast, returns one
// result: the signed Q31.32 value (zero on error) and a status code. A digit or point
// is taken in the idle state. Other characters first convert a pending number, then
// run each reduction in turn through the shared unit, which iterates for multiply,
// divide, remainder and conversion but not for add/sub. The speed is set by the shared
// arithmetic unit and by the single read port of each stack memory;
// s_tready is low while an item is being worked.
module infix_expression_evaluator_top import iee_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] value
	output logic [2:0]  m_tuser    // [2:0] status
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CONV   = 4'd1;
	localparam logic [3:0] S_OP     = 4'd2;
	localparam logic [3:0] S_LOOP   = 4'd3;
	localparam logic [3:0] S_LOOPRD = 4'd4;
	localparam logic [3:0] S_DRAIN  = 4'd5;
	localparam logic [3:0] S_RED    = 4'd6;
	localparam logic [3:0] S_RB     = 4'd7;
	localparam logic [3:0] S_RA     = 4'd8;
	localparam logic [3:0] S_ALU    = 4'd9;
	localparam logic [3:0] S_FINCHK = 4'd10;
	localparam logic [3:0] S_EMIT   = 4'd11;
	localparam logic [3:0] S_TAIL   = 4'd12;

	localparam logic [1:0] M_BIN   = 2'd0;
	localparam logic [1:0] M_CLOSE = 2'd1;
	localparam logic [1:0] M_FINAL = 2'd2;

	localparam logic [CNT_W-1:0] DEPTH = CNT_W'(STACK_DEPTH);

	logic [3:0]       state_q;
	logic [1:0]       mode_q;
	logic [7:0]       ch_q;
	logic             last_q;
	logic             tail_q;
	logic [CNT_W-1:0] ot_q;
	logic [CNT_W-1:0] vt_q;
	logic [VAL_W-1:0] mant_q;
	logic [DC_W-1:0]  fd_q;
	logic [DC_W-1:0]  dc_q;
	logic [2:0]       flags_q;
	logic [2:0]       err_q;
	logic [2:0]       code_q;
	logic [VAL_W-1:0] b_q;
	logic             m_tvalid_q;
	logic [VAL_W-1:0] m_data_q;
	logic [2:0]       m_user_q;

	logic [2:0]       os_mem [STACK_DEPTH];
	logic [VAL_W-1:0] vs_mem [STACK_DEPTH];
	logic [2:0]       op_rd_q;
	logic [VAL_W-1:0] vs_rd_q;

	logic             accept;
	logic             is_digit;
	logic             is_point;
	logic             is_oper;
	logic [3:0]       post_st;
	logic [3:0]       back_st;
	logic [2:0]       in_code;
	logic             os_full;
	logic             vs_full;
	logic             push_req;
	logic [2:0]       push_code;
	logic             vs_we;
	logic [SD_W-1:0]  vs_wa;
	logic [VAL_W-1:0] vs_wd;
	logic [SD_W-1:0]  vs_ra;
	logic [CNT_W-1:0] vt_m1;
	logic [CNT_W-1:0] vt_m2;
	logic [CNT_W-1:0] ot_m1;
	logic [VAL_W-1:0] mant_x10;
	logic [2:0]       base_flags;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;
	logic [VAL_W-1:0] alu_a;
	logic [VAL_W-1:0] alu_res;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
	assign is_point = (s_tdata == CH_POINT);
	assign is_oper  = (ch_q == CH_PLUS) || (ch_q == CH_MINUS) || (ch_q == CH_STAR)
		|| (ch_q == CH_SLASH) || (ch_q == CH_PCT);
	assign post_st  = last_q ? S_TAIL : S_IDLE;
	assign back_st  = (mode_q == M_FINAL) ? S_DRAIN : S_LOOP;
	assign in_code  = char_to_op(ch_q);
	assign os_full  = (ot_q == DEPTH);
	assign vs_full  = (vt_q == DEPTH);
	assign vt_m1    = vt_q - 1'b1;
	assign vt_m2    = vt_q - CNT_W'(2);
	assign ot_m1    = ot_q - 1'b1;
	assign mant_x10 = (mant_q << 3) + (mant_q << 1);
	assign base_flags = flags_q[0] ? flags_q : 3'b001;

	always_comb begin
		push_req  = 1'b0;
		push_code = in_code;
		case (state_q)
			S_OP: begin
				push_req  = (err_q == ST_OK) && (ch_q == CH_LPAREN) && !os_full;
				push_code = OP_LPAREN;
			end
			S_LOOP:   push_req = (err_q == ST_OK) && (mode_q == M_BIN) && (ot_q == '0);
			S_LOOPRD: push_req = (mode_q == M_BIN) && (level_of(op_rd_q) < level_of(in_code))
				&& !os_full;
			default:  push_req = 1'b0;
		endcase
	end

	always_comb begin
		vs_we = 1'b0;
		vs_wa = vt_m2[SD_W-1:0];
		vs_wd = alu_res;
		if (state_q == S_CONV && alu_rsp.done && !vs_full) begin
			vs_we = 1'b1;
			vs_wa = vt_q[SD_W-1:0];
		end else if (state_q == S_ALU && alu_rsp.done && !alu_rsp.div_zero) begin
			vs_we = 1'b1;
		end
		case (state_q)
			S_RED:   vs_ra = vt_m1[SD_W-1:0];
			S_RB:    vs_ra = vt_m2[SD_W-1:0];
			default: vs_ra = '0;
		endcase
	end

	always_comb begin
		alu_req.start = (accept && err_q == ST_OK && !is_digit && !is_point && flags_q[0])
			|| (state_q == S_TAIL && err_q == ST_OK && flags_q[0])
			|| (state_q == S_RA);
		alu_req.op    = (state_q == S_RA) ? code_q : OP_CVT;
		alu_a         = (state_q == S_RA) ? vs_rd_q : mant_q;
	end

	iee_alu u_alu (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (alu_req),
		.a           (alu_a),
		.b           (b_q),
		.frac_digits (fd_q),
		.rsp         (alu_rsp),
		.res         (alu_res)
	);

	always_ff @(posedge clk) begin
		if (push_req)
			os_mem[ot_q[SD_W-1:0]] <= push_code;
		op_rd_q <= os_mem[ot_m1[SD_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (vs_we)
			vs_mem[vs_wa] <= vs_wd;
		vs_rd_q <= vs_mem[vs_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= M_BIN;
			last_q     <= 1'b0;
			tail_q     <= 1'b0;
			ot_q       <= '0;
			vt_q       <= '0;
			mant_q     <= '0;
			fd_q       <= '0;
			dc_q       <= '0;
			flags_q    <= '0;
			err_q      <= ST_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready && state_q != S_EMIT)
				m_tvalid_q <= 1'b0;
			if (push_req)
				ot_q <= ot_q + 1'b1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q   <= s_tdata;
						last_q <= s_tlast;
						if (err_q != ST_OK) begin
							state_q <= s_tlast ? S_TAIL : S_IDLE;
						end else if (is_digit || is_point) begin
							state_q <= s_tlast ? S_TAIL : S_IDLE;
							if (is_point) begin
								flags_q <= base_flags[1] ? (base_flags | 3'b100)
									: (base_flags | 3'b010);
								if (!flags_q[0]) begin
									mant_q <= '0;
									fd_q   <= '0;
									dc_q   <= '0;
								end
							end else begin
								flags_q <= base_flags;
								if (!flags_q[0]) begin
									// first digit of a new number
									mant_q <= {{(VAL_W-4){1'b0}}, s_tdata[3:0]};
									fd_q   <= '0;
									dc_q   <= DC_W'(1);
								end else if (!flags_q[2]) begin
									if (dc_q >= DC_W'(MAX_DIGITS)) begin
										err_q <= ST_LONG;
									end else begin
										mant_q <= mant_x10
											+ {{(VAL_W-4){1'b0}}, s_tdata[3:0]};
										dc_q   <= dc_q + 1'b1;
										if (flags_q[1])
											fd_q <= fd_q + 1'b1;
									end
								end
							end
						end else if (flags_q[0]) begin
							state_q <= S_CONV;
						end else begin
							state_q <= S_OP;
						end
					end
				end
				S_TAIL: begin
					tail_q <= 1'b1;
					mode_q <= M_FINAL;
					state_q <= (err_q == ST_OK && flags_q[0]) ? S_CONV : S_DRAIN;
				end
				S_CONV: begin
					if (alu_rsp.done) begin
						flags_q <= '0;
						if (vs_full)
							err_q <= ST_OVF;
						else
							vt_q <= vt_q + 1'b1;
						state_q <= tail_q ? S_DRAIN : S_OP;
					end
				end
				S_OP: begin
					if (err_q != ST_OK) begin
						state_q <= post_st;
					end else if (ch_q == CH_LPAREN) begin
						if (os_full)
							err_q <= ST_OVF;
						state_q <= post_st;
					end else if (ch_q == CH_RPAREN) begin
						mode_q  <= M_CLOSE;
						state_q <= S_LOOP;
					end else if (is_oper) begin
						mode_q  <= M_BIN;
						state_q <= S_LOOP;
					end else begin
						state_q <= post_st;
					end
				end
				S_LOOP: begin
					if (err_q != ST_OK) begin
						state_q <= post_st;
					end else if (ot_q == '0) begin
						if (mode_q == M_CLOSE)
							err_q <= ST_MALF;
						state_q <= post_st;
					end else begin
						state_q <= S_LOOPRD;
					end
				end
				S_LOOPRD: begin
					if (mode_q == M_CLOSE) begin
						if (op_rd_q != OP_LPAREN) begin
							state_q <= S_RED;
						end else begin
							ot_q    <= ot_m1;
							state_q <= post_st;
						end
					end else if (level_of(op_rd_q) >= level_of(in_code)) begin
						state_q <= S_RED;
					end else begin
						if (os_full)
							err_q <= ST_OVF;
						state_q <= post_st;
					end
				end
				S_DRAIN: begin
					state_q <= (err_q != ST_OK || ot_q == '0) ? S_FINCHK : S_RED;
				end
				S_RED: begin
					ot_q   <= ot_m1;
					code_q <= op_rd_q;
					if (op_rd_q == OP_LPAREN || op_rd_q > OP_REM || vt_q < CNT_W'(2)) begin
						err_q   <= ST_MALF;
						state_q <= back_st;
					end else begin
						state_q <= S_RB;
					end
				end
				S_RB: begin
					b_q     <= vs_rd_q;
					state_q <= S_RA;
				end
				S_RA: state_q <= S_ALU;
				S_ALU: begin
					if (alu_rsp.done) begin
						if (alu_rsp.div_zero)
							err_q <= ST_DIVZ;
						else
							vt_q <= vt_m1;
						state_q <= back_st;
					end
				end
				S_FINCHK: begin
					if (err_q == ST_OK && vt_q != CNT_W'(1))
						err_q <= ST_MALF;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_data_q   <= (err_q == ST_OK) ? vs_rd_q : '0;
						m_user_q   <= err_q;
						ot_q       <= '0;
						vt_q       <= '0;
						mant_q     <= '0;
						fd_q       <= '0;
						dc_q       <= '0;
						flags_q    <= '0;
						err_q      <= ST_OK;
						tail_q     <= 1'b0;
						last_q     <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == S_CONV || state_q == S_ALU))
		else $error("ALU result with no one waiting");

	a_stack_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(ot_q <= DEPTH) && (vt_q <= DEPTH))
		else $error("stack pointer beyond depth");

	a_error_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
		else $error("nonzero value with error status");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && (!m_tvalid_q || m_tready)) |=> (err_q == ST_OK && vt_q == '0))
		else $error("expression state not cleared after result");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for infix_expression_evaluator_top.
// Expression characters go in as stream items, and a scoreboard class predicts each result.
// Depends on iee_pkg and on the RTL of the evaluator.
class expr_scoreboard;
	typedef struct {
		logic [63:0] value;
		logic [2:0]  status;
	} result_t;

	bit [2:0]  ops[iee_pkg::STACK_DEPTH];
	bit [63:0] vals[iee_pkg::STACK_DEPTH];
	int        otop, vtop, ndig, nfrac;
	bit [63:0] mant;
	bit [2:0]  flags;
	bit [2:0]  err;
	result_t   results_due[$];
	int        errors;

	function new();
		clear();
		errors = 0;
	endfunction

	function void clear();
		otop = 0; vtop = 0; ndig = 0; nfrac = 0; mant = 0; flags = 0; err = iee_pkg::ST_OK;
	endfunction

	function void fail_with(bit [2:0] e);
		if (err == iee_pkg::ST_OK) err = e;
	endfunction

	function int rank(bit [2:0] c);
		if (c == iee_pkg::OP_ADD || c == iee_pkg::OP_SUB) return 1;
		if (c == iee_pkg::OP_LPAREN) return 0;
		return 2;
	endfunction

	function bit [63:0] saturate(bit neg, bit [63:0] mag, bit ovf);
		if (neg) return (ovf || mag > iee_pkg::NEG_MIN) ? iee_pkg::NEG_MIN : -mag;
		return (ovf || mag > iee_pkg::POS_MAX) ? iee_pkg::POS_MAX : mag;
	endfunction

	function bit [63:0] magnitude(bit [63:0] a);
		return a[63] ? -a : a;
	endfunction

	// decimal mantissa/10^f to fixed point, round half up
	function bit [63:0] decimal_to_fixed(bit [63:0] m, int f);
		bit [63:0] p, ip, r, frac, v;
		p = 1; frac = 0;
		repeat (f) p = p * 10;
		ip = m / p;
		r = m % p;
		repeat (iee_pkg::FRAC_BITS) begin
			frac = frac << 1;
			if (r >= p - r) begin
				r = r - (p - r);
				frac[0] = 1'b1;
			end else begin
				r = r + r;
			end
		end
		if (ip > (iee_pkg::POS_MAX >> iee_pkg::FRAC_BITS)) return iee_pkg::POS_MAX;
		v = (ip << iee_pkg::FRAC_BITS) | frac;
		if (r >= p - r) begin
			if (v == iee_pkg::POS_MAX) return iee_pkg::POS_MAX;
			v = v + 1;
		end
		return v;
	endfunction

	function void reduce_top();
		bit [2:0]   c;
		bit [63:0]  a, b, s, ma, mb;
		bit [127:0] w;
		if (otop == 0) begin
			fail_with(iee_pkg::ST_MALF);
			return;
		end
		otop--;
		c = ops[otop];
		if (c == iee_pkg::OP_LPAREN || c > iee_pkg::OP_REM || vtop < 2) begin
			fail_with(iee_pkg::ST_MALF);
			return;
		end
		vtop--;
		b = vals[vtop];
		a = vals[vtop-1];
		ma = magnitude(a);
		mb = magnitude(b);
		case (c)
			iee_pkg::OP_ADD: begin
				s = a + b;
				if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? iee_pkg::NEG_MIN : iee_pkg::POS_MAX;
			end
			iee_pkg::OP_SUB: begin
				s = a - b;
				if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? iee_pkg::NEG_MIN : iee_pkg::POS_MAX;
			end
			iee_pkg::OP_MUL: begin
				w = {64'd0, ma} * {64'd0, mb};
				s = saturate(a[63] ^ b[63], w[iee_pkg::FRAC_BITS +: 64],
					(w >> (64 + iee_pkg::FRAC_BITS)) != 0);
			end
			iee_pkg::OP_DIV: begin
				if (b == 0) begin
					fail_with(iee_pkg::ST_DIVZ);
					return;
				end
				w = ({64'd0, ma} << iee_pkg::FRAC_BITS) / {64'd0, mb};
				s = saturate(a[63] ^ b[63], w[63:0], w[127:64] != 0);
			end
			default: begin
				if (b == 0) begin
					fail_with(iee_pkg::ST_DIVZ);
					return;
				end
				s = saturate(a[63], ma % mb, 1'b0);
			end
		endcase
		vals[vtop-1] = s;
	endfunction

	function void push_op(bit [2:0] c);
		if (otop >= iee_pkg::STACK_DEPTH) begin
			fail_with(iee_pkg::ST_OVF);
			return;
		end
		ops[otop++] = c;
	endfunction

	function void close_number();
		flags = 0;
		if (vtop >= iee_pkg::STACK_DEPTH) begin
			fail_with(iee_pkg::ST_OVF);
			return;
		end
		vals[vtop++] = decimal_to_fixed(mant, nfrac);
	endfunction

	function void take_digit(bit [7:0] ch);
		if (!flags[0]) begin
			mant = 0; nfrac = 0; ndig = 0; flags = 3'b001;
		end
		if (ch == iee_pkg::CH_POINT) begin
			if (flags[1]) flags[2] = 1'b1;
			else flags[1] = 1'b1;
			return;
		end
		if (flags[2]) return;
		if (ndig >= iee_pkg::MAX_DIGITS) begin
			fail_with(iee_pkg::ST_LONG);
			return;
		end
		mant = mant * 10 + 64'(ch - iee_pkg::CH_ZERO);
		ndig++;
		if (flags[1]) nfrac++;
	endfunction

	function void take_operator(bit [7:0] ch);
		bit [2:0] c;
		if (ch == iee_pkg::CH_LPAREN) begin
			push_op(iee_pkg::OP_LPAREN);
			return;
		end
		if (ch == iee_pkg::CH_RPAREN) begin
			while (otop > 0 && ops[otop-1] != iee_pkg::OP_LPAREN && err == iee_pkg::ST_OK)
				reduce_top();
			if (err != iee_pkg::ST_OK) return;
			if (otop == 0) fail_with(iee_pkg::ST_MALF);
			else otop--;
			return;
		end
		case (ch)
			iee_pkg::CH_PLUS:  c = iee_pkg::OP_ADD;
			iee_pkg::CH_MINUS: c = iee_pkg::OP_SUB;
			iee_pkg::CH_STAR:  c = iee_pkg::OP_MUL;
			iee_pkg::CH_SLASH: c = iee_pkg::OP_DIV;
			default:           c = iee_pkg::OP_REM;
		endcase
		while (otop > 0 && err == iee_pkg::ST_OK && rank(ops[otop-1]) >= rank(c))
			reduce_top();
		if (err == iee_pkg::ST_OK) push_op(c);
	endfunction

	// one accepted input item
	function void note_char(bit [7:0] ch, bit last);
		result_t r;
		if (err == iee_pkg::ST_OK) begin
			if ((ch >= iee_pkg::CH_ZERO && ch <= iee_pkg::CH_NINE) || ch == iee_pkg::CH_POINT) begin
				take_digit(ch);
			end else begin
				if (flags[0]) close_number();
				if (err == iee_pkg::ST_OK && ch inside {iee_pkg::CH_PLUS, iee_pkg::CH_MINUS,
					iee_pkg::CH_STAR, iee_pkg::CH_SLASH, iee_pkg::CH_PCT,
					iee_pkg::CH_LPAREN, iee_pkg::CH_RPAREN})
					take_operator(ch);
			end
		end
		if (!last) return;
		if (err == iee_pkg::ST_OK && flags[0]) close_number();
		while (err == iee_pkg::ST_OK && otop > 0) reduce_top();
		if (err == iee_pkg::ST_OK && vtop != 1) fail_with(iee_pkg::ST_MALF);
		r.value = (err == iee_pkg::ST_OK) ? vals[0] : 64'd0;
		r.status = err;
		results_due.push_back(r);
		clear();
	endfunction

	task report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	task check_result(logic [63:0] value, logic [2:0] status);
		result_t r;
		if (results_due.size() == 0) begin
			report($sformatf("unexpected result value=%h status=%0d", value, status));
			return;
		end
		r = results_due.pop_front();
		if (value !== r.value)
			report($sformatf("value %h, expected %h", value, r.value));
		if (status !== r.status)
			report($sformatf("status %0d, expected %0d", status, r.status));
	endtask
endclass

module tb_top import iee_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 200000;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tlast;
	logic [7:0]  s_tdata;
	logic        m_tvalid, m_tready;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;

	expr_scoreboard sb = new();
	bit   steady;      // no idling on either side while set
	int   chars_sent;
	int   stalled;
	byte unsigned text[$];

	infix_expression_evaluator_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: random back-pressure, check, watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stalled  <= 0;
		end else begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
			stalled <= ((m_tvalid && m_tready) || (s_tvalid && s_tready)) ? 0 : stalled + 1;
			if (stalled >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
			m_tready <= steady || ($urandom_range(99) >= 30);
		end
	end

	task send_char(byte unsigned ch, bit last);
		if (!steady && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_char(ch, last);
		chars_sent++;
	endtask

	task send_text(string s);
		foreach (s[i]) send_char(s[i], i == s.len() - 1);
	endtask

	task flush_text();
		foreach (text[i]) send_char(text[i], i == text.size() - 1);
		text.delete();
	endtask

	task automatic add_number();
		int n;
		n = ($urandom_range(19) == 0) ? $urandom_range(22, 15) : $urandom_range(6, 1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) text.push_back(CH_POINT);
			else text.push_back(CH_ZERO + 8'($urandom_range(9)));
		end
	endtask

	task automatic add_sum(int depth);
		int terms;
		terms = $urandom_range(3, 1);
		for (int t = 0; t < terms; t++) begin
			if (t > 0) begin
				case ($urandom_range(4))
					0: text.push_back(CH_PLUS);
					1: text.push_back(CH_MINUS);
					2: text.push_back(CH_STAR);
					3: text.push_back(CH_SLASH);
					default: text.push_back(CH_PCT);
				endcase
			end
			if ($urandom_range(15) == 0) text.push_back(" ");
			if (depth < 4 && $urandom_range(3) == 0) begin
				text.push_back(CH_LPAREN);
				add_sum(depth + 1);
				text.push_back(CH_RPAREN);
			end else begin
				add_number();
			end
		end
	endtask

	initial begin
		string nest;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		steady = 1'b0;
		chars_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("7");
		send_text("1+2*3-4/5%3");
		send_text("(1.5+2)*3");
		send_text("7/0");
		send_text("7%0");
		send_text("-5");
		send_text("1+2)");
		send_text("(1");
		send_text("1 2");
		send_text(" ");
		send_text("12345678901234567890");
		send_text("1..5.9+.");
		send_text("9999999999*9999999999");
		send_text("0-9999999999*9999999999");
		send_text("9999999999/0.0000000001");
		send_text("0.9999999999999999999");
		send_text("0-7.25%2");
		nest = "";
		repeat (STACK_DEPTH + 1) nest = {nest, "("};
		send_text({nest, "1"});
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);

		while (chars_sent < 1950) begin
			steady = (chars_sent > 800 && chars_sent < 1100);
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(6, 1)) text.push_back(8'($urandom_range(255)));
			end else begin
				add_sum(0);
				if ($urandom_range(14) == 0) text.delete($urandom_range(text.size() - 1));
			end
			if (text.size() == 0) text.push_back(CH_ZERO);
			flush_text();
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		while (sb.results_due.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/iee_pkg.sv
hw/rtl/iee_alu.sv
hw/rtl/infix_expression_evaluator_top.sv
dv/tb_top.sv
